// ----- design/twr_pkg.sv -----
// ----------------------------------------------------------------------------
// twr_pkg
// shared types and constants for the three-wire register access master
// ----------------------------------------------------------------------------
package twr_pkg;

   localparam int CMD_W   = 2;
   localparam int ADDR_W  = 7;
   localparam int DATA_W  = 16;
   localparam int TICK_W  = 8;
   localparam int SHIFT_W = 24;
   localparam int BITC_W  = 5;

   // request codes
   localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 8'd4;

   // bit counts for address and data fields
   localparam logic [BITC_W-1:0] ADDR_BITS  = 5'd8;
   localparam logic [BITC_W-1:0] DATA_BITS  = 5'd16;
   localparam logic [BITC_W-1:0] TOTAL_BITS = 5'd24;
   localparam logic [BITC_W-1:0] LAST_POS   = 5'd23;

   typedef enum logic [7:0] {
      PH_IDLE  = 8'b0000_0001,
      PH_START = 8'b0000_0010,
      PH_WSET  = 8'b0000_0100,
      PH_WLOW  = 8'b0000_1000,
      PH_WHIGH = 8'b0001_0000,
      PH_RHIGH = 8'b0010_0000,
      PH_RLOW  = 8'b0100_0000,
      PH_STOP  = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ADDR_W-1:0] reg_address;
      logic [DATA_W-1:0] write_data;
      logic              sda_in;
   } req_payload_type;

   typedef struct packed {
      logic              select_n;
      logic              bus_clock;
      logic              sda_out;
      logic              sda_drive;
      logic              busy_res;
      logic              access_done;
      logic [DATA_W-1:0] read_data;
   } rsp_payload_type;

endpackage

// ----- design/twr_req_if.sv -----
// ----------------------------------------------------------------------------
// twr_req_if
// tick channel into the master: one transfer per bus tick
// ----------------------------------------------------------------------------
interface twr_req_if import twr_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [ADDR_W-1:0] reg_address;
   logic [DATA_W-1:0] write_data;
   logic              sda_in;

   modport source (output valid, command, reg_address, write_data, sda_in, input ready);
   modport sink   (input valid, command, reg_address, write_data, sda_in, output ready);
endinterface

// ----- design/twr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// twr_rsp_if
// pin level channel out of the master: one transfer per bus tick
// ----------------------------------------------------------------------------
interface twr_rsp_if import twr_pkg::*;;
   logic              valid;
   logic              ready;
   logic              select_n;
   logic              bus_clock;
   logic              sda_out;
   logic              sda_drive;
   logic              busy_res;
   logic              access_done;
   logic [DATA_W-1:0] read_data;

   modport source (output valid, select_n, bus_clock, sda_out, sda_drive, busy_res,
                   access_done, read_data, input ready);
   modport sink   (input valid, select_n, bus_clock, sda_out, sda_drive, busy_res,
                   access_done, read_data, output ready);
endinterface

// ----- design/twr_in_stage.sv -----
// ----------------------------------------------------------------------------
// twr_in_stage
// input register for incoming ticks, issues the step strobe
// ----------------------------------------------------------------------------
module twr_in_stage import twr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  req_payload_type in_data,
   input  logic            sink_open,
   output logic            step,
   output req_payload_type item
);

   logic            valid_ff;
   logic            valid_in;
   req_payload_type data_ff;

   assign step     = valid_ff & sink_open;
   assign in_ready = ~valid_ff | step;
   assign valid_in = (in_valid & in_ready) | (valid_ff & ~step);
   assign item     = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid & in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

// ----- design/twr_seq.sv -----
// ----------------------------------------------------------------------------
// twr_seq
// bus phase sequencer: state update and pin levels for one tick
// ----------------------------------------------------------------------------
module twr_seq import twr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  req_payload_type   item,
   input  logic [TICK_W-1:0] phase_ticks,
   output rsp_payload_type   result
);

   phase_type            phase_ff, phase_in;
   logic [BITC_W-1:0]    bit_count_ff, bit_count_in;
   logic [SHIFT_W-1:0]   out_shift_ff, out_shift_in;
   logic [DATA_W-1:0]    in_shift_ff, in_shift_in;
   logic [TICK_W-1:0]    tick_count_ff, tick_count_in;
   logic                 is_read_ff, is_read_in;

   logic [TICK_W-1:0]    plen;
   logic [TICK_W:0]      cnt;
   logic [BITC_W-1:0]    bc_inc;
   logic [BITC_W-1:0]    bit_pos;
   logic                 write_bit;
   logic                 done;
   logic [DATA_W-1:0]    rdata;

   assign plen   = (phase_ticks == '0) ? 8'd1 : phase_ticks;
   assign cnt    = {1'b0, tick_count_ff} + 9'd1;
   assign bc_inc = bit_count_ff + 5'd1;

   // next state
   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      out_shift_in  = out_shift_ff;
      in_shift_in   = in_shift_ff;
      tick_count_in = tick_count_ff;
      is_read_in    = is_read_ff;
      done          = 1'b0;
      rdata         = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (item.command == CMD_WRITE || item.command == CMD_READ) begin
               is_read_in    = (item.command == CMD_READ);
               out_shift_in  = {is_read_in, item.reg_address,
                                (is_read_in ? 16'd0 : item.write_data)};
               in_shift_in   = '0;
               bit_count_in  = '0;
               tick_count_in = '0;
               phase_in      = PH_START;
            end
         end
         default: begin
            if (cnt < {1'b0, plen}) begin
               tick_count_in = cnt[TICK_W-1:0];
            end else begin
               tick_count_in = '0;
               case (phase_ff)
                  PH_START: phase_in = PH_WSET;
                  PH_WSET:  phase_in = PH_WLOW;
                  PH_WLOW:  phase_in = PH_WHIGH;
                  PH_WHIGH: begin
                     if (is_read_ff && bc_inc >= ADDR_BITS) begin
                        bit_count_in = '0;
                        phase_in     = PH_RHIGH;
                     end else if (bc_inc >= TOTAL_BITS) begin
                        bit_count_in = bc_inc;
                        phase_in     = PH_STOP;
                     end else begin
                        bit_count_in = bc_inc;
                        phase_in     = PH_WSET;
                     end
                  end
                  PH_RHIGH: phase_in = PH_RLOW;
                  PH_RLOW: begin
                     in_shift_in  = {in_shift_ff[DATA_W-2:0], item.sda_in};
                     bit_count_in = bc_inc;
                     phase_in     = (bc_inc >= DATA_BITS) ? PH_STOP : PH_RHIGH;
                  end
                  PH_STOP: begin
                     done         = 1'b1;
                     rdata        = is_read_ff ? in_shift_ff : '0;
                     phase_in     = PH_IDLE;
                     bit_count_in = '0;
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
      endcase
   end

   // pin levels after this tick's update
   assign bit_pos   = LAST_POS - bit_count_in;
   assign write_bit = (bit_count_in < TOTAL_BITS) ? out_shift_in[bit_pos] : 1'b1;

   always_comb begin
      result             = '0;
      result.select_n    = 1'b1;
      result.bus_clock   = 1'b1;
      result.sda_out     = 1'b1;
      result.sda_drive   = 1'b1;
      result.busy_res    = (phase_in != PH_IDLE);
      result.access_done = done;
      result.read_data   = rdata;
      case (phase_in)
         PH_WSET, PH_WHIGH: begin
            result.select_n = 1'b0;
            result.sda_out  = write_bit;
         end
         PH_WLOW: begin
            result.select_n  = 1'b0;
            result.bus_clock = 1'b0;
            result.sda_out   = write_bit;
         end
         PH_RHIGH: begin
            result.select_n  = 1'b0;
            result.sda_drive = 1'b0;
            result.sda_out   = out_shift_in[DATA_W];
         end
         PH_RLOW: begin
            result.select_n  = 1'b0;
            result.bus_clock = 1'b0;
            result.sda_drive = 1'b0;
            result.sda_out   = out_shift_in[DATA_W];
         end
         PH_STOP: begin
            result.bus_clock = ~is_read_in;
            result.sda_out   = is_read_in ? out_shift_in[DATA_W] : out_shift_in[0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         out_shift_ff  <= '0;
         in_shift_ff   <= '0;
         tick_count_ff <= '0;
         is_read_ff    <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         out_shift_ff  <= out_shift_in;
         in_shift_ff   <= in_shift_in;
         tick_count_ff <= tick_count_in;
         is_read_ff    <= is_read_in;
      end
   end

endmodule

// ----- design/twr_out_stage.sv -----
// ----------------------------------------------------------------------------
// twr_out_stage
// result register holding one tick's pin levels until taken
// ----------------------------------------------------------------------------
module twr_out_stage import twr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  rsp_payload_type load_data,
   output logic            sink_open,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_payload_type out_data
);

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type data_ff;

   assign sink_open = ~valid_ff | out_ready;
   assign valid_in  = load | (valid_ff & ~out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

// ----- design/three_wire_register_access_master.sv -----
// ----------------------------------------------------------------------------
// three_wire_register_access_master
// three-wire serial register access master, one bus tick per transfer
// ----------------------------------------------------------------------------
// path: a tick's pin levels reach rsp via the input and result registers
// throughput: one tick per cycle unless rsp stalls, set by the single-pass
//   sequencer update
// reset: synchronous, active high; bus phase goes idle, counters and shift
//   registers clear, phase_ticks returns to 4
module three_wire_register_access_master import twr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [TICK_W-1:0] csr_wr_data,
   twr_req_if.sink           req_chan,
   twr_rsp_if.source         rsp_chan
);

   // ticks per bus phase, zero acts as one
   logic [TICK_W-1:0] phase_ticks_ff;

   req_payload_type req_data;
   req_payload_type item;
   rsp_payload_type result;
   rsp_payload_type rsp_data;
   logic            step;
   logic            sink_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else if (csr_wr_en) begin
         phase_ticks_ff <= csr_wr_data;
      end
   end

   // gather the tick payload from the channel
   assign req_data.command     = req_chan.command;
   assign req_data.reg_address = req_chan.reg_address;
   assign req_data.write_data  = req_chan.write_data;
   assign req_data.sda_in      = req_chan.sda_in;

   // input register, steps the sequencer when the result side has room
   twr_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (req_data),
      .sink_open (sink_open),
      .step      (step),
      .item      (item)
   );

   // phase sequencer and pin level decode
   twr_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (item),
      .phase_ticks (phase_ticks_ff),
      .result      (result)
   );

   // result register, lets a new tick in as the last one is taken
   twr_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .load_data (result),
      .sink_open (sink_open),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.select_n    = rsp_data.select_n;
   assign rsp_chan.bus_clock   = rsp_data.bus_clock;
   assign rsp_chan.sda_out     = rsp_data.sda_out;
   assign rsp_chan.sda_drive   = rsp_data.sda_drive;
   assign rsp_chan.busy_res    = rsp_data.busy_res;
   assign rsp_chan.access_done = rsp_data.access_done;
   assign rsp_chan.read_data   = rsp_data.read_data;

   // the finishing tick already shows the bus idle
   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.access_done) |-> !rsp_chan.busy_res)
      else $error("access_done with busy_res set");

   // read data only leaves with the finishing tick
   a_rdata_done : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.access_done) |-> (rsp_chan.read_data == '0))
      else $error("read_data outside access_done");

   // the data line is only released inside a selected transfer
   a_release_sel : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.sda_drive) |-> (!rsp_chan.select_n && rsp_chan.busy_res))
      else $error("data line released outside transfer");

   // idle bus sits with every line high
   a_idle_high : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.busy_res) |->
         (rsp_chan.select_n && rsp_chan.bus_clock && rsp_chan.sda_out && rsp_chan.sda_drive))
      else $error("idle bus not all high");

endmodule
